### hw/rtl/thresholded_cross_window_average_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thresholded cross-window average block
// Shared helpers that wrap clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef THRESHOLDED_CROSS_WINDOW_AVERAGE_DEFINES_SVH
`define THRESHOLDED_CROSS_WINDOW_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCWA_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tcwa check failed");

// Next-cycle implication, disabled during reset.
`define TCWA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tcwa check failed");

`endif

### hw/rtl/tcwa_pkg.sv
// ----------------------------------------------------------------------------
// Thresholded cross-window average package
// Shared constants, register indexes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none
package tcwa_pkg;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_RADIUS = 16;
   localparam int MAX_HEIGHT     = 4096;
   localparam int SAMPLE_W       = 8;
   localparam int FW_W           = 12;
   localparam int FH_W           = 13;
   localparam int WR_W           = 5;
   localparam int TH_W           = 8;
   localparam int CSR_W          = 13;
   localparam int CSR_IDX_W      = 2;

   localparam logic [FW_W-1:0] FW_RESET = 12'd2048;
   localparam logic [FH_W-1:0] FH_RESET = 13'd1080;
   localparam logic [WR_W-1:0] WR_RESET = 5'd2;
   localparam logic [TH_W-1:0] TH_RESET = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_RADIUS       = 2'd2,
      REG_THRESHOLD    = 2'd3
   } tcwa_reg_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CENTER = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_OUT    = 6'b100000
   } tcwa_state_type;
endpackage
`default_nettype wire

### hw/rtl/tcwa_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read synchronous memory holding the ring of
// sample rows; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module tcwa_line_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/tcwa_divider.sv
// ----------------------------------------------------------------------------
// Window mean divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tcwa_divider #(
   parameter int NUM_W = 14,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             bit_q;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      bit_q  = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = bit_q ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], bit_q};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

### hw/rtl/thresholded_cross_window_average.sv
// ----------------------------------------------------------------------------
// Thresholded cross-window average
// Raster-order plane filter: the mean of a clipped cross window where the
// sample exceeds a threshold, zero elsewhere.
// ----------------------------------------------------------------------------
// One beat is taken per item; a pixel beat writes its sample into the line
// store in the cycle it is taken. Items before the window lag yield no
// result. An item whose delayed pixel does not exceed the threshold passes
// through the center, check and output states. An item that yields a window
// mean also reads its n window samples, where n is the clipped window size,
// at most 4r - 2 for radius r, through the single read port of the line store,
// which fetches one window sample per cycle, and then waits for the bit-serial
// divider. A finished result waits in the output register while the next item
// is taken. Any register write restarts the frame; the line store keeps its
// contents and needs no clearing after reset.
`default_nettype none
`include "thresholded_cross_window_average_defines.svh"
module thresholded_cross_window_average #(
   parameter int MAX_WIDTH  = tcwa_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = tcwa_pkg::DEF_MAX_RADIUS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tcwa_pkg::SAMPLE_W-1:0]   req_tdata,  // sample
   input  wire logic                            req_tuser,  // operation
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [tcwa_pkg::SAMPLE_W-1:0]   rsp_tdata,  // mask_value
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [tcwa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcwa_pkg::CSR_W-1:0]      csr_wdata
);
   import tcwa_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(2 * MAX_RADIUS + 1);
   localparam int RING  = 2 * MAX_RADIUS - 1;
   localparam int ROW_W = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int PW    = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS) + 1);
   localparam int DEPTH = MAX_WIDTH * RING;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(4 * MAX_RADIUS);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic [WR_W-1:0] wr_ff;
   logic [TH_W-1:0] th_ff;

   logic [WW-1:0]   w_c;
   logic [FH_W-1:0] h_c;
   logic [RW-1:0]   r_c, rm1_c, ring_c;
   logic [PW-1:0]   lag_c;

   tcwa_state_type state_ff, state_in;
   logic [WW-1:0]    icol_ff, icol_in, ocol_ff, ocol_in, hcol_ff, hcol_in;
   logic [ROW_W-1:0] irow_ff, irow_in, orow_ff, orow_in;
   logic [RW-1:0]    islot_ff, islot_in, oslot_ff, oslot_in, vslot_ff, vslot_in;
   logic [PW-1:0]    p_ff, p_in;
   logic [CNT_W-1:0] hleft_ff, hleft_in, vleft_ff, vleft_in, cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept, active, take, wr_en, rd_en, div_start, div_done, load;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SUM_W-1:0] quot;
   logic [RW-1:0]    fwd, bck, fwdv, bckv;
   logic [WW-1:0]    w_minus_x;
   logic [FH_W:0]    h_minus_y;
   logic             eof;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] slot,
                                             input logic [WW-1:0] col);
      return AW'(AW'(slot) * AW'(MAX_WIDTH) + AW'(col));
   endfunction

   function automatic logic [RW-1:0] slot_inc(input logic [RW-1:0] slot,
                                              input logic [RW-1:0] ring);
      return (slot + RW'(1) >= ring) ? '0 : slot + RW'(1);
   endfunction

   always_comb begin
      if (fw_ff == '0) begin
         w_c = WW'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_c = WW'(MAX_WIDTH);
      end else begin
         w_c = WW'(fw_ff);
      end
      if (fh_ff == '0) begin
         h_c = FH_W'(1);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         h_c = FH_W'(MAX_HEIGHT);
      end else begin
         h_c = fh_ff;
      end
      if (wr_ff < WR_W'(2)) begin
         r_c = RW'(2);
      end else if (32'(wr_ff) > MAX_RADIUS) begin
         r_c = RW'(MAX_RADIUS);
      end else begin
         r_c = RW'(wr_ff);
      end
      rm1_c  = r_c - RW'(1);
      ring_c = RW'({r_c, 1'b0} - (RW + 1)'(1));
      lag_c  = PW'(PW'(rm1_c) * PW'(w_c)) + PW'(rm1_c);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign active     = 32'(irow_ff) < 32'(h_c);
   assign take       = accept && !(active && req_tuser);
   assign wr_en      = accept && active && !req_tuser;
   assign wr_addr    = addr_of(islot_ff, icol_ff);
   assign load       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign eof        = (ocol_ff + WW'(1) >= w_c) && (32'(orow_ff) + 1 >= 32'(h_c));

   always_comb begin
      w_minus_x = w_c - ocol_ff;
      h_minus_y = (FH_W + 1)'(h_c) - (FH_W + 1)'(orow_ff);
      fwd  = (32'(w_minus_x) < 32'(r_c)) ? RW'(w_minus_x) : r_c;
      bck  = (32'(ocol_ff) < 32'(rm1_c)) ? RW'(ocol_ff) : rm1_c;
      fwdv = (32'(h_minus_y) < 32'(r_c)) ? RW'(h_minus_y) : r_c;
      bckv = (32'(orow_ff) < 32'(rm1_c)) ? RW'(orow_ff) : rm1_c;
   end

   always_comb begin
      state_in = state_ff;
      icol_in = icol_ff;  irow_in = irow_ff;  islot_in = islot_ff;
      ocol_in = ocol_ff;  orow_in = orow_ff;  oslot_in = oslot_ff;
      p_in = p_ff;  hcol_in = hcol_ff;  vslot_in = vslot_ff;
      hleft_in = hleft_ff;  vleft_in = vleft_ff;  cnt_in = cnt_ff;
      pend_in = 1'b0;  acc_in = acc_ff;  value_in = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;  rsp_last_in = rsp_last_ff;
      rd_en = 1'b0;  rd_addr = addr_of(oslot_ff, ocol_ff);
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               p_in = p_ff + PW'(1);
               if (icol_ff + WW'(1) >= w_c) begin
                  icol_in  = '0;
                  irow_in  = irow_ff + ROW_W'(1);
                  islot_in = slot_inc(islot_ff, ring_c);
               end else begin
                  icol_in = icol_ff + WW'(1);
               end
               if (p_ff >= lag_c) begin
                  state_in = ST_CENTER;
               end
            end
         end
         ST_CENTER: begin
            rd_en    = 1'b1;
            hcol_in  = ocol_ff - WW'(bck);
            hleft_in = CNT_W'(fwd) + CNT_W'(bck);
            vleft_in = CNT_W'(fwdv) + CNT_W'(bckv);
            cnt_in   = CNT_W'(fwd) + CNT_W'(bck) + CNT_W'(fwdv) + CNT_W'(bckv);
            vslot_in = (oslot_ff >= bckv) ? oslot_ff - bckv : oslot_ff + ring_c - bckv;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            acc_in = '0;
            if (rd_data > th_ff) begin
               state_in = ST_SUM;
            end else begin
               value_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               acc_in = acc_ff + SUM_W'(rd_data);
            end
            if (hleft_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = addr_of(oslot_ff, hcol_ff);
               hcol_in  = hcol_ff + WW'(1);
               hleft_in = hleft_ff - CNT_W'(1);
               pend_in  = 1'b1;
            end else if (vleft_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = addr_of(vslot_ff, ocol_ff);
               vslot_in = slot_inc(vslot_ff, ring_c);
               vleft_in = vleft_ff - CNT_W'(1);
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               value_in = quot[SAMPLE_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = value_ff;
               rsp_last_in  = eof;
               state_in     = ST_IDLE;
               if (ocol_ff + WW'(1) >= w_c) begin
                  ocol_in  = '0;
                  orow_in  = orow_ff + ROW_W'(1);
                  oslot_in = slot_inc(oslot_ff, ring_c);
               end else begin
                  ocol_in = ocol_ff + WW'(1);
               end
               if (eof) begin
                  icol_in = '0;  irow_in = '0;  islot_in = '0;
                  ocol_in = '0;  orow_in = '0;  oslot_in = '0;
                  p_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         icol_in = '0;  irow_in = '0;  islot_in = '0;
         ocol_in = '0;  orow_in = '0;  oslot_in = '0;
         p_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
         wr_ff <= WR_RESET;
         th_ff <= TH_RESET;
         state_ff <= ST_IDLE;
         icol_ff <= '0;  irow_ff <= '0;  islot_ff <= '0;
         ocol_ff <= '0;  orow_ff <= '0;  oslot_ff <= '0;
         p_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (tcwa_reg_type'(csr_index))
               REG_FRAME_WIDTH:  fw_ff <= csr_wdata[FW_W-1:0];
               REG_FRAME_HEIGHT: fh_ff <= csr_wdata[FH_W-1:0];
               REG_RADIUS:       wr_ff <= csr_wdata[WR_W-1:0];
               REG_THRESHOLD:    th_ff <= csr_wdata[TH_W-1:0];
               default:          fw_ff <= fw_ff;
            endcase
         end
         state_ff <= state_in;
         icol_ff <= icol_in;  irow_ff <= irow_in;  islot_ff <= islot_in;
         ocol_ff <= ocol_in;  orow_ff <= orow_in;  oslot_ff <= oslot_in;
         p_ff <= p_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hcol_ff  <= hcol_in;
      vslot_ff <= vslot_in;
      hleft_ff <= hleft_in;
      vleft_ff <= vleft_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   tcwa_line_store #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .DW   (SAMPLE_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_tdata),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   tcwa_divider #(
      .NUM_W(SUM_W),
      .DEN_W(CNT_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(acc_ff),
      .denom(cnt_ff),
      .done (div_done),
      .quot (quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TCWA_ASSERT_SAME(a_div_nonzero, div_start, cnt_ff != '0)
   `TCWA_ASSERT_NEXT(a_div_to_out, (state_ff == ST_DIV) && div_done, state_ff == ST_OUT)
   `TCWA_ASSERT_NEXT(a_eof_restart, load && eof && !csr_we, (p_ff == '0) && (irow_ff == '0))
endmodule
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Thresholded cross-window average testbench
// Streams frames of many sizes, radii and thresholds through the block.
// Every accepted item is run through a local predictor, and each result beat
// is checked against the oldest predicted mask value and end-of-frame flag.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcwa_pkg::*;

   localparam int STORE_COLS = DEF_MAX_WIDTH;
   localparam int STORE_ROWS = 2 * DEF_MAX_RADIUS - 1;

   typedef struct packed {
      logic       drain;
      logic [7:0] sample;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] mask;
      logic       eof;
   } mask_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [SAMPLE_W-1:0]  rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   thresholded_cross_window_average uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pixel_item_type  pending_items[$];
   mask_result_type mask_expect[$];
   logic [7:0]      line_copy [0:STORE_COLS*STORE_ROWS-1];

   logic [FW_W-1:0] cfg_width;
   logic [FH_W-1:0] cfg_height;
   logic [WR_W-1:0] cfg_radius;
   logic [TH_W-1:0] cfg_threshold;
   int unsigned in_col, in_row, out_col, out_row;

   int unsigned mismatches, results_seen, frames_run, pixels_sent, req_gap, rsp_stall;
   int unsigned items_sent;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int unsigned store_at(int unsigned row, int unsigned col,
                                            int unsigned ring);
      return line_copy[(row % ring) * STORE_COLS + (col % STORE_COLS)];
   endfunction

   task automatic predict_mask(input pixel_item_type it);
      int unsigned w, h, r, ring, p, lag, x, y, sum, fwd, bck, fwdv, bckv, i;
      mask_result_type res;
      w = clampu(cfg_width, 1, DEF_MAX_WIDTH);
      h = clampu(cfg_height, 1, MAX_HEIGHT);
      r = clampu(cfg_radius, 2, DEF_MAX_RADIUS);
      ring = 2 * r - 1;
      if (in_row < h) begin
         if (it.drain) return;
         line_copy[(in_row % ring) * STORE_COLS + in_col] = it.sample;
      end
      p = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      lag = (r - 1) * w + (r - 1);
      if (p < lag) return;
      x = out_col;
      y = out_row;
      res.mask = 8'd0;
      res.eof = 1'b0;
      if (store_at(y, x, ring) > cfg_threshold) begin
         fwd = (r < w - x) ? r : w - x;
         bck = (r - 1 < x) ? r - 1 : x;
         fwdv = (r < h - y) ? r : h - y;
         bckv = (r - 1 < y) ? r - 1 : y;
         sum = 0;
         for (i = x - bck; i < x + fwd; i++) sum += store_at(y, i, ring);
         for (i = y - bckv; i < y + fwdv; i++) sum += store_at(i, x, ring);
         res.mask = 8'(sum / (fwd + bck + fwdv + bckv));
      end
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) begin
            res.eof = 1'b1;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
      end
      mask_expect.push_back(res);
   endtask

   // Register shadow; every write restarts the frame.
   always @(posedge clock) begin
      if (!reset && csr_we) begin
         case (tcwa_reg_type'(csr_index))
            REG_FRAME_WIDTH:  cfg_width = csr_wdata[FW_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = csr_wdata[FH_W-1:0];
            REG_RADIUS:       cfg_radius = csr_wdata[WR_W-1:0];
            REG_THRESHOLD:    cfg_threshold = csr_wdata[TH_W-1:0];
            default: ;
         endcase
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
   end

   // Request driver.
   always @(posedge clock) begin
      pixel_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_mask({req_tuser, req_tdata});
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_tuser <= it.drain;
               req_tdata <= it.sample;
               req_tvalid <= 1'b1;
               req_gap = calm ? 0 : $urandom_range(0, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure.
   always @(posedge clock) begin
      mask_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (mask_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: mask %0d last %0b", rsp_tdata, rsp_tlast);
            end else begin
               exp_res = mask_expect.pop_front();
               if (rsp_tdata !== exp_res.mask || rsp_tlast !== exp_res.eof) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected mask %0d last %0b, got mask %0d last %0b",
                              exp_res.mask, exp_res.eof, rsp_tdata, rsp_tlast);
               end
            end
            rsp_stall = calm ? 0 : $urandom_range(0, 15);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_tvalid || mask_expect.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(input tcwa_reg_type idx, input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_sample();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   // Sets up one frame and queues its pixels and drains; noise adds ignored
   // early drains and extra pixels in the tail.
   task automatic run_frame(input int unsigned w_raw, input int unsigned h_raw,
                            input int unsigned r_raw, input int unsigned thr,
                            input bit noise);
      int unsigned w, h, r, lag, n;
      pixel_item_type it;
      wait_idle();
      csr_write(REG_FRAME_WIDTH, w_raw);
      csr_write(REG_FRAME_HEIGHT, h_raw);
      csr_write(REG_RADIUS, r_raw);
      csr_write(REG_THRESHOLD, thr);
      w = clampu(w_raw % (1 << FW_W), 1, DEF_MAX_WIDTH);
      h = clampu(h_raw % (1 << FH_W), 1, MAX_HEIGHT);
      r = clampu(r_raw % (1 << WR_W), 2, DEF_MAX_RADIUS);
      lag = (r - 1) * w + (r - 1);
      frames_run++;
      for (n = 0; n < w * h; n++) begin
         if (noise && $urandom_range(0, 9) == 0) begin
            it.drain = 1'b1;
            it.sample = 8'($urandom);
            pending_items.push_back(it);
            items_sent++;
         end
         it.drain = 1'b0;
         it.sample = pick_sample();
         pending_items.push_back(it);
         items_sent++;
         pixels_sent++;
      end
      for (n = 0; n < lag; n++) begin
         it.drain = !(noise && $urandom_range(0, 5) == 0);
         it.sample = 8'($urandom);
         pending_items.push_back(it);
         items_sent++;
      end
   endtask

   initial begin
      int unsigned w, h, r, thr;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_width = FW_RESET;
      cfg_height = FH_RESET;
      cfg_radius = WR_RESET;
      cfg_threshold = TH_RESET;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      mismatches = 0; results_seen = 0; frames_run = 0; pixels_sent = 0;
      items_sent = 0;
      calm = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: tiny sizes, clamped register values, threshold extremes.
      run_frame(3, 3, 2, 0, 1'b1);
      run_frame(1, 1, 2, 128, 1'b0);
      run_frame(0, 0, 1, 255, 1'b1);
      run_frame(2, 3, 31, 0, 1'b0);
      calm = 1'b0;
      run_frame(24, 4, 16, 100, 1'b0);
      run_frame(5, 3, 3, 200, 1'b0);

      while (items_sent < 1750) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) % 32 : $urandom_range(1, 20);
         h = $urandom_range(0, 14);
         r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 5);
         thr = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 255 : 0)
                                           : $urandom_range(0, 255);
         calm = ($urandom_range(0, 4) == 0);
         run_frame(w, h, r, thr, $urandom_range(0, 2) == 0);
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("Ran %0d frames with %0d items (%0d pixels); %0d result beats checked.",
               frames_run, items_sent, pixels_sent, results_seen);
      if (mismatches == 0 && mask_expect.size() == 0) begin
         $display("** thresholded_cross_window_average: PASSED **");
      end else begin
         $display("Mismatches: %0d, results still expected: %0d",
                  mismatches, mask_expect.size());
         $display("** thresholded_cross_window_average: FAILED **");
      end
      $finish;
   end

   initial begin
      #(12 * 2_000_000);
      $display("Timeout with %0d results still expected.", mask_expect.size());
      $display("** thresholded_cross_window_average: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
